>>> rtl/core/bsr_pkg.sv
// Shared types and constants for the BMP scanline to RGB24 converter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bsr_pkg;

  // Image limits and palette size
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PAL_DEPTH  = 256;
  localparam int PAL_AW     = $clog2(PAL_DEPTH);

  // Field and counter widths
  localparam int CFG_W = 11;   // width and height registers
  localparam int POS_W = 12;   // byte offset within a row stride
  localparam int ROW_W = 11;   // rows received, saturates at MAX_HEIGHT
  localparam int X_W   = 10;   // pixel column
  localparam int Y_W   = 10;   // top-down line number
  localparam int RGB_W = 24;
  localparam int LANES = 8;    // most pixels one byte can yield
  localparam int LANE_W = $clog2(LANES);

  // Pixel formats
  localparam logic [1:0] FMT_MONO  = 2'd0;
  localparam logic [1:0] FMT_PAL4  = 2'd1;
  localparam logic [1:0] FMT_PAL8  = 2'd2;
  localparam logic [1:0] FMT_BGR24 = 2'd3;

  // Item kinds
  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_PIXEL     = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Mono colours
  localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000000;
  localparam logic [RGB_W-1:0] RGB_WHITE = 24'hffffff;

  typedef struct packed {
    logic       opcode;
    logic [7:0] palette_index;
    logic [23:0] palette_color;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] pixel_x;
    logic [9:0] line_y;
    logic       last_of_item;
  } pixel_t;

  // Palette port requests from the stream decoder
  typedef struct packed {
    logic              wr_en;
    logic [PAL_AW-1:0] wr_addr;
    logic [RGB_W-1:0]  wr_color;
    logic              rd_en;
    logic [PAL_AW-1:0] rd_addr0;
    logic [PAL_AW-1:0] rd_addr1;
  } pal_req_t;

  // One decoded byte waiting to be expanded into pixels
  typedef struct packed {
    logic [1:0]       fmt;
    logic [7:0]       data_byte;
    logic [RGB_W-1:0] rgb;
    logic [LANES-1:0] mask;
    logic [X_W-1:0]   x_base;
    logic [Y_W-1:0]   line_y;
  } work_t;

endpackage

>>> rtl/core/bmp_scanline_to_rgb24.sv
// Top level of the BMP scanline to RGB24 converter.
// Depends on bsr_pkg, bsr_palette, bsr_decode and bsr_expand.
`timescale 1ns / 1ps

// Channel   Signals                                   Transfer when
// item      item_valid, item_ready, item (item_t)     item_valid && item_ready
// pixel     pixel_valid, pixel_ready, pixel (pixel_t) pixel_valid && pixel_ready
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid (cfg_ready tied high)
//
// A byte yields at most 8 pixels at 1 bpp and 2 at 4 bpp; they leave one per
// transfer through the single pixel output port, and the next byte is taken as
// the last pixel of the current one leaves. A pixel passes from the expansion
// stage register to the output register. Reset clears position, row count and
// pending bytes and restores default configuration; palette contents are kept
// undefined. A stalled pixel output holds the expansion stage and then input.

module bmp_scanline_to_rgb24 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [bsr_pkg::CFG_W-1:0] cfg_data,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  bsr_pkg::item_t            item,
  output logic                      pixel_valid,
  input  logic                      pixel_ready,
  output bsr_pkg::pixel_t           pixel
);
  import bsr_pkg::*;

  pal_req_t         pal_req;
  logic [RGB_W-1:0] rd_color0;
  logic [RGB_W-1:0] rd_color1;
  logic             load;
  work_t            work_in;
  logic             free;
  logic             accept;

  assign cfg_ready  = 1'b1;
  assign item_ready = free;
  assign accept     = item_valid && free;

  bsr_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .pal_req   (pal_req),
    .load      (load),
    .work_in   (work_in)
  );

  bsr_palette u_palette (
    .clk       (clk),
    .req       (pal_req),
    .rd_color0 (rd_color0),
    .rd_color1 (rd_color1)
  );

  bsr_expand u_expand (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .work_in     (work_in),
    .rd_color0   (rd_color0),
    .rd_color1   (rd_color1),
    .free        (free),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

endmodule

>>> rtl/core/bsr_palette.sv
// Palette memory: one write port and two registered read ports.
// Depends on bsr_pkg for widths and the request struct.
`timescale 1ns / 1ps

module bsr_palette (
  input  logic                            clk,
  input  bsr_pkg::pal_req_t               req,
  output logic [bsr_pkg::RGB_W-1:0]       rd_color0,
  output logic [bsr_pkg::RGB_W-1:0]       rd_color1
);
  import bsr_pkg::*;

  logic [RGB_W-1:0] mem [PAL_DEPTH];

  // Store palette entries
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_color;
    end
  end

  // Fetch both lookups for a pixel byte; hold otherwise
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_color0 <= mem[req.rd_addr0];
      rd_color1 <= mem[req.rd_addr1];
    end
  end

endmodule

>>> rtl/core/bsr_decode.sv
// Stream decoder: configuration registers, row and byte position tracking,
// 24 bpp byte assembly, and decode of each byte into a set of pixels.
// Depends on bsr_pkg.
`timescale 1ns / 1ps

module bsr_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [1:0]                cfg_index,
  input  logic [bsr_pkg::CFG_W-1:0] cfg_data,
  input  logic                      accept,
  input  bsr_pkg::item_t            item,
  output bsr_pkg::pal_req_t         pal_req,
  output logic                      load,
  output bsr_pkg::work_t            work_in
);
  import bsr_pkg::*;

  // Configuration
  logic [1:0]       pixel_format;
  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] image_height;

  // Stream state
  logic [POS_W-1:0] pos;
  logic [X_W-1:0]   pos_q;    // pos / 3
  logic [1:0]       pos_r;    // pos % 3
  logic [ROW_W-1:0] rows;
  logic [15:0]      pend;
  logic [1:0]       pend_cnt;

  logic [POS_W-1:0] pos_next;
  logic [X_W-1:0]   pos_q_next;
  logic [1:0]       pos_r_next;
  logic [ROW_W-1:0] rows_next;
  logic [15:0]      pend_next;
  logic [1:0]       pend_cnt_next;

  logic [CFG_W-1:0] width_c;
  logic [CFG_W-1:0] height_c;
  logic [POS_W-1:0] width3;
  logic [POS_W-1:0] row_bytes;
  logic [POS_W-1:0] stride;
  logic [POS_W:0]   pos_inc;
  logic             live;
  logic             is_pixel;
  logic             in_px;
  logic             emit24;
  logic [LANES-1:0] mask;
  logic [X_W-1:0]   x_base;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_BGR24;
      line_width   <= CFG_W'(1);
      image_height <= CFG_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FORMAT: pixel_format <= cfg_data[1:0];
        REG_WIDTH:  line_width   <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Clamp geometry and derive the padded row stride
  always_comb begin
    priority if (line_width == '0) width_c = CFG_W'(1);
    else if (line_width > CFG_W'(MAX_WIDTH)) width_c = CFG_W'(MAX_WIDTH);
    else width_c = line_width;

    priority if (image_height == '0) height_c = CFG_W'(1);
    else if (image_height > CFG_W'(MAX_HEIGHT)) height_c = CFG_W'(MAX_HEIGHT);
    else height_c = image_height;

    width3 = POS_W'(width_c) + (POS_W'(width_c) << 1);

    unique case (pixel_format)
      FMT_MONO:  row_bytes = (POS_W'(width_c) + POS_W'(7)) >> 3;
      FMT_PAL4:  row_bytes = (POS_W'(width_c) + POS_W'(1)) >> 1;
      FMT_PAL8:  row_bytes = POS_W'(width_c);
      default:   row_bytes = width3;
    endcase
    stride = (row_bytes + POS_W'(3)) & ~POS_W'(3);
  end

  // Decode the byte into pixels
  always_comb begin
    is_pixel = item.opcode == OP_PIXEL;
    live     = (rows < ROW_W'(height_c)) && (pos < stride);
    in_px    = pos < width3;
    emit24   = in_px && ((pend_cnt >= 2'd2) || (pos_r == 2'd2));
    mask     = '0;
    x_base   = '0;
    unique case (pixel_format)
      FMT_MONO: begin
        for (int i = 0; i < LANES; i++) begin
          mask[i] = {pos, LANE_W'(i)} < (POS_W + LANE_W)'(width_c);
        end
        x_base = X_W'({pos, LANE_W'(0)});
      end
      FMT_PAL4: begin
        mask[0] = {pos, 1'b0} < (POS_W + 1)'(width_c);
        mask[1] = {pos, 1'b1} < (POS_W + 1)'(width_c);
        x_base  = X_W'({pos, 1'b0});
      end
      FMT_PAL8: begin
        mask[0] = pos < POS_W'(width_c);
        x_base  = X_W'(pos);
      end
      default: begin
        mask[0] = emit24;
        x_base  = pos_q;
      end
    endcase
    if (!live) begin
      mask = '0;
    end
  end

  // Pending BGR bytes and position advance
  always_comb begin
    pend_next     = pend;
    pend_cnt_next = pend_cnt;
    if (live && pixel_format == FMT_BGR24 && in_px) begin
      priority if (emit24) begin
        pend_next     = '0;
        pend_cnt_next = '0;
      end else if (pend_cnt == 2'd0) begin
        pend_next     = {8'h00, item.data_byte};
        pend_cnt_next = 2'd1;
      end else begin
        pend_next     = {item.data_byte, pend[7:0]};
        pend_cnt_next = pend_cnt + 2'd1;
      end
    end

    pos_inc = {1'b0, pos} + (POS_W + 1)'(1);
    rows_next = rows;
    if (pos_inc >= {1'b0, stride}) begin
      pos_next      = '0;
      pos_q_next    = '0;
      pos_r_next    = '0;
      pend_next     = '0;
      pend_cnt_next = '0;
      if (rows < ROW_W'(MAX_HEIGHT)) begin
        rows_next = rows + ROW_W'(1);
      end
    end else begin
      pos_next = pos_inc[POS_W-1:0];
      if (pos_r == 2'd2) begin
        pos_r_next = 2'd0;
        pos_q_next = pos_q + X_W'(1);
      end else begin
        pos_r_next = pos_r + 2'd1;
        pos_q_next = pos_q;
      end
    end
  end

  // Advance stream state on each pixel byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      pos_q    <= '0;
      pos_r    <= '0;
      rows     <= '0;
      pend     <= '0;
      pend_cnt <= '0;
    end else if (accept && is_pixel) begin
      pos      <= pos_next;
      pos_q    <= pos_q_next;
      pos_r    <= pos_r_next;
      rows     <= rows_next;
      pend     <= pend_next;
      pend_cnt <= pend_cnt_next;
    end
  end

  // Palette port requests
  always_comb begin
    pal_req.wr_en    = accept && !is_pixel &&
                       ({1'b0, item.palette_index} < 9'(PAL_DEPTH));
    pal_req.wr_addr  = PAL_AW'(item.palette_index);
    pal_req.wr_color = item.palette_color;
    pal_req.rd_en    = accept && is_pixel;
    pal_req.rd_addr0 = (pixel_format == FMT_PAL4) ? PAL_AW'(item.data_byte[7:4])
                                                  : PAL_AW'(item.data_byte);
    pal_req.rd_addr1 = PAL_AW'(item.data_byte[3:0]);
  end

  // Hand the decoded byte to the expansion stage
  assign load              = accept && is_pixel && (mask != '0);
  assign work_in.fmt       = pixel_format;
  assign work_in.data_byte = item.data_byte;
  assign work_in.rgb       = {item.data_byte, pend[15:8], pend[7:0]};
  assign work_in.mask      = mask;
  assign work_in.x_base    = x_base;
  assign work_in.line_y    = Y_W'(height_c - CFG_W'(1) - CFG_W'(rows));

endmodule

>>> rtl/core/bsr_expand.sv
// Expansion stage: holds one decoded byte and sends its pixels, one per
// transfer, through the output register. Depends on bsr_pkg.
`timescale 1ns / 1ps

module bsr_expand (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  bsr_pkg::work_t            work_in,
  input  logic [bsr_pkg::RGB_W-1:0] rd_color0,
  input  logic [bsr_pkg::RGB_W-1:0] rd_color1,
  output logic                      free,
  output logic                      pixel_valid,
  input  logic                      pixel_ready,
  output bsr_pkg::pixel_t           pixel
);
  import bsr_pkg::*;

  logic             work_valid;
  work_t            work;
  logic [LANES-1:0] rest;
  logic [LANE_W-1:0] lane;
  logic             last;
  logic             fire;
  logic [RGB_W-1:0] color;
  pixel_t           pixel_next;

  // Pick the lowest pending lane
  always_comb begin
    lane = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (work.mask[i]) begin
        lane = LANE_W'(i);
      end
    end
    rest = work.mask & ~(LANES'(1) << lane);
    last = rest == '0;
  end

  // Colour of the selected pixel
  always_comb begin
    unique case (work.fmt)
      FMT_MONO:  color = work.data_byte[LANE_W'(LANES - 1) - lane] ? RGB_BLACK
                                                                    : RGB_WHITE;
      FMT_PAL4:  color = (lane == '0) ? rd_color0 : rd_color1;
      FMT_PAL8:  color = rd_color0;
      default:   color = work.rgb;
    endcase
    pixel_next.red          = color[23:16];
    pixel_next.green        = color[15:8];
    pixel_next.blue         = color[7:0];
    pixel_next.pixel_x      = work.x_base + X_W'(lane);
    pixel_next.line_y       = work.line_y;
    pixel_next.last_of_item = last;
  end

  assign fire = work_valid && (!pixel_valid || pixel_ready);
  assign free = !work_valid || (fire && last);

  // Hold the byte until its last pixel leaves; a new byte replaces it
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (load) begin
      work_valid <= 1'b1;
    end else if (fire && last) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= work_in;
    end else if (fire) begin
      work.mask <= rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (fire) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pixel <= pixel_next;
    end
  end

endmodule

>>> tb/sv/tb_bmp_scanline_to_rgb24.sv
// Self-checking testbench for bmp_scanline_to_rgb24: drives palette writes and
// pixel-array bytes, predicts every RGB pixel and checks them in order.
// Depends on bsr_pkg and the bmp_scanline_to_rgb24 top level.
`timescale 1ns / 1ps

module tb_bmp_scanline_to_rgb24;
  import bsr_pkg::*;

  // Register index with no register behind it; writes to it must change nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Cycles to let a byte with no pixels clear the pipeline before a register write
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES = 40;

  // Scoreboard: own copy of the converter state, queue of pixels still due
  class pixel_scoreboard;
    logic [RGB_W-1:0] palette [PAL_DEPTH];
    int unsigned byte_pos;
    int unsigned rows_done;
    logic [15:0] partial_bgr;
    int unsigned partial_cnt;
    logic [1:0] reg_format;
    logic [CFG_W-1:0] reg_width;
    logic [CFG_W-1:0] reg_height;
    pixel_t pixels_due[$];
    pixel_t held;
    bit held_valid;
    int fails;

    function new();
      foreach (palette[i]) palette[i] = '0;
      byte_pos = 0;
      rows_done = 0;
      partial_bgr = '0;
      partial_cnt = 0;
      reg_format = FMT_BGR24;
      reg_width = 11'd1;
      reg_height = 11'd1;
      fails = 0;
      held_valid = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned row_stride();
      int unsigned w, n;
      w = clamp(reg_width, MAX_WIDTH);
      case (reg_format)
        FMT_MONO: n = (w + 7) / 8;
        FMT_PAL4: n = (w + 1) / 2;
        FMT_PAL8: n = w;
        default:  n = w * 3;
      endcase
      return (n + 3) & ~32'd3;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FORMAT: reg_format = data[1:0];
        REG_WIDTH:  reg_width = data;
        REG_HEIGHT: reg_height = data;
        default: ;
      endcase
    endfunction

    // Hold one pixel back so the last of a byte can be marked before queueing
    function void add_pixel(logic [RGB_W-1:0] rgb, int unsigned x, int unsigned y);
      pixel_t p;
      p.red = rgb[23:16];
      p.green = rgb[15:8];
      p.blue = rgb[7:0];
      p.pixel_x = x[9:0];
      p.line_y = y[9:0];
      p.last_of_item = 1'b0;
      if (held_valid) pixels_due.push_back(held);
      held = p;
      held_valid = 1;
    endfunction

    // Note an accepted input item and queue the pixels it produces
    function void note_item(item_t it);
      int unsigned w, h, s, pos, x, y;
      logic [7:0] b;
      bit live;
      if (it.opcode == OP_PAL_WRITE) begin
        palette[it.palette_index] = it.palette_color;
        return;
      end
      w = clamp(reg_width, MAX_WIDTH);
      h = clamp(reg_height, MAX_HEIGHT);
      s = row_stride();
      pos = byte_pos;
      b = it.data_byte;
      live = (rows_done < h) && (pos < s);
      y = live ? (h - 1 - rows_done) : 0;
      held_valid = 0;
      if (live) begin
        case (reg_format)
          FMT_MONO: begin
            for (int i = 0; i < 8; i++) begin
              x = pos * 8 + i;
              if (x < w) add_pixel(b[7 - i] ? RGB_BLACK : RGB_WHITE, x, y);
            end
          end
          FMT_PAL4: begin
            if (pos * 2 < w) add_pixel(palette[b[7:4]], pos * 2, y);
            if (pos * 2 + 1 < w) add_pixel(palette[b[3:0]], pos * 2 + 1, y);
          end
          FMT_PAL8: begin
            if (pos < w) add_pixel(palette[b], pos, y);
          end
          default: begin
            // Collect B then G; the R byte, or a third byte, completes the pixel
            if (pos < w * 3) begin
              if (partial_cnt >= 2 || pos % 3 == 2) begin
                add_pixel({b, partial_bgr[15:8], partial_bgr[7:0]}, pos / 3, y);
                partial_bgr = '0;
                partial_cnt = 0;
              end else begin
                if (partial_cnt == 0) partial_bgr = {8'h00, b};
                else partial_bgr = {b, partial_bgr[7:0]};
                partial_cnt++;
              end
            end
          end
        endcase
      end
      if (held_valid) begin
        held.last_of_item = 1'b1;
        pixels_due.push_back(held);
      end
      // Advance within the stride; close the row at its end
      pos++;
      if (pos >= s) begin
        pos = 0;
        partial_bgr = '0;
        partial_cnt = 0;
        if (rows_done < MAX_HEIGHT) rows_done++;
      end
      byte_pos = pos;
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        fails++;
      end
    endfunction

    // Check one transferred pixel against the oldest one due
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        $error("pixel with none due: x %0d y %0d", got.pixel_x, got.line_y);
        fails++;
        return;
      end
      want = pixels_due.pop_front();
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
      compare("pixel_x", want.pixel_x, got.pixel_x);
      compare("line_y", want.line_y, got.line_y);
      compare("last_of_item", want.last_of_item, got.last_of_item);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic pixel_valid;
  logic pixel_ready = 1'b0;
  pixel_t pixel;

  pixel_scoreboard sb = new();
  int burst_left = 0;
  bit pal_written [PAL_DEPTH];
  int written_idx[$];

  bmp_scanline_to_rgb24 u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[bmp_scanline_to_rgb24] ERROR");
    $finish;
  end

  // Receiver: stall in modes of random length, from never to mostly
  initial begin
    int mode, len;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 80);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: pixel_ready <= 1'b1;
          1: pixel_ready <= 1'($urandom_range(0, 1));
          2: pixel_ready <= ($urandom_range(0, 3) == 0);
          default: pixel_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Check every pixel transfer
  always @(posedge clk) begin
    if (!rst && pixel_valid && pixel_ready) sb.check_pixel(pixel);
  end

  // Send one item in bursts with random gaps; note it once transferred
  task drive_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    burst_left--;
  endtask

  task send_byte(input logic [7:0] b);
    item_t it;
    it.opcode = OP_PIXEL;
    it.palette_index = 8'($urandom);
    it.palette_color = 24'($urandom);
    it.data_byte = b;
    drive_item(it);
  endtask

  task write_palette(input int idx, input logic [RGB_W-1:0] colour);
    item_t it;
    it.opcode = OP_PAL_WRITE;
    it.palette_index = idx[7:0];
    it.palette_color = colour;
    it.data_byte = 8'($urandom);
    drive_item(it);
    if (!pal_written[idx]) begin
      pal_written[idx] = 1;
      written_idx.push_back(idx);
    end
  endtask

  // Drop valid, wait for every pixel due, then let the pipeline settle
  task drain();
    item_valid <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task put_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write all registers while idle; stray upper format bits must be ignored
  task configure(input logic [1:0] fmt, input logic [CFG_W-1:0] w,
                 input logic [CFG_W-1:0] h);
    logic [8:0] junk;
    drain();
    junk = 9'($urandom);
    put_reg(REG_FORMAT, {junk, fmt});
    put_reg(REG_WIDTH, w);
    put_reg(REG_HEIGHT, h);
    if ($urandom_range(0, 3) == 0) put_reg(REG_UNUSED, CFG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Pixel byte content; at 8 bpp only indexes already written
  function logic [7:0] next_byte();
    if (sb.reg_format == FMT_PAL8)
      return 8'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
    return 8'($urandom);
  endfunction

  initial begin
    int sent, n, s, rem, rows;
    logic [1:0] fmt;
    logic [CFG_W-1:0] w, h;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Mono, bottom line of a full-height image: all white, all black, then padding
    configure(FMT_MONO, 11'd16, 11'd2047);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'ha5);
    send_byte(8'h5a);

    write_palette(0, 24'hffffff);
    write_palette(15, 24'h000000);
    write_palette(255, 24'h3c5aa5);

    // 4 bpp, odd width: the last low nibble falls beyond the row
    configure(FMT_PAL4, 11'd3, 11'd1024);
    send_byte(8'h0f);
    send_byte(8'hf0);
    send_byte(8'h3c);
    send_byte(8'hc3);

    // 8 bpp, top palette index, then padding
    configure(FMT_PAL8, 11'd1, 11'd1024);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h12);
    send_byte(8'h34);

    // 24 bpp, two pixels and two padding bytes
    configure(FMT_BGR24, 11'd2, 11'd1024);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h77);
    send_byte(8'h88);

    // One full row at the clamped widest width reaches the last column
    configure(FMT_MONO, 11'd2047, 11'd2047);
    n = sb.row_stride() - sb.byte_pos;
    repeat (n) send_byte(8'($urandom));

    // Random phases: mostly whole rows, some broken-off runs
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      fmt = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = 11'd2047;
        2: w = 11'($urandom_range(13, 1024));
        default: w = 11'($urandom_range(1, 12));
      endcase
      rows = sb.rows_done;
      case ($urandom_range(0, 9))
        0: h = '0;
        1: h = 11'd2047;
        2: h = 11'(rows);
        default: h = 11'(rows + $urandom_range(1, 8));
      endcase
      configure(fmt, w, h);

      if (fmt == FMT_PAL4) begin
        for (int i = 0; i < 16; i++)
          if (!pal_written[i]) write_palette(i, 24'($urandom));
      end else if (fmt == FMT_PAL8) begin
        repeat ($urandom_range(1, 4))
          write_palette($urandom_range(0, 255), 24'($urandom));
      end

      if ($urandom_range(0, 4) != 0) begin
        s = sb.row_stride();
        rem = (sb.byte_pos < s) ? s - sb.byte_pos : 1;
        n = rem + s * $urandom_range(0, 2);
        if (n > 40) n = $urandom_range(1, 40);
      end else begin
        n = $urandom_range(1, 12);
      end

      repeat (n) begin
        if ($urandom_range(0, 19) == 0)
          write_palette($urandom_range(0, 255), 24'($urandom));
        send_byte(next_byte());
        sent++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("[bmp_scanline_to_rgb24] OK");
    end else begin
      $display("[bmp_scanline_to_rgb24] ERROR");
    end
    $finish;
  end

endmodule
